### rtl/core/oakt_pkg.sv
`default_nettype none

package oakt_pkg;

  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 8;
  localparam int KEY_IN_W = 63;
  localparam int KEY_LEN_W = 4;

  typedef struct packed {
    logic load;
    logic adv;
    logic mode;
  } oakt_step_ctl_t;

endpackage

`default_nettype wire

### rtl/core/oakt_hash.sv
`default_nettype none

module oakt_hash
  import oakt_pkg::*;
#(
  parameter int SLOTS = 32,
  parameter int KEY_BYTES = 8,
  localparam int POS_W = $clog2(SLOTS),
  localparam int KEY_W = (KEY_BYTES == 8) ? KEY_IN_W : 8 * KEY_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [KEY_IN_W-1:0]  key_bytes,
  input  wire logic [KEY_LEN_W-1:0] key_length,
  output logic      [KEY_W-1:0]     key,
  output logic      [POS_W-1:0]     home,
  output logic                      done
);

  localparam int HS_W = KEY_BYTES + 8;
  localparam int NPAIR = (HS_W + 1) / 2;
  localparam int HS_PAD = 2 * NPAIR;
  localparam int CNT_W = $clog2(NPAIR);
  localparam logic [POS_W:0] SLOTS_V = (POS_W + 1)'(SLOTS);

  logic [63:0]          bytes64;
  logic [KEY_LEN_W-1:0] lim;
  logic                 live;
  logic [63:0]          kc;
  logic [HS_W-1:0]      s;
  logic [7:0]           c;

  logic [KEY_W-1:0]  key_r;
  logic [HS_PAD-1:0] sh_r;
  logic [POS_W-1:0]  rem_r;
  logic [POS_W-1:0]  rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [POS_W:0]    r1;
  logic [POS_W:0]    r2;

  always_comb begin
    bytes64 = {1'b0, key_bytes};
    lim = (key_length > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES) : key_length;
    live = 1'b1;
    kc = '0;
    s = '0;
    c = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      c = bytes64[8*i +: 8];
      if (live && (KEY_LEN_W'(i) < lim) && (c != 8'h00)) begin
        kc[8*i +: 8] = c;
        s = (s ^ HS_W'(c)) << 1;
      end else begin
        live = 1'b0;
      end
    end
  end

  always_comb begin
    r1 = {rem_r, sh_r[HS_PAD-1]};
    if (r1 >= SLOTS_V) begin
      r1 = r1 - SLOTS_V;
    end
    r2 = {r1[POS_W-1:0], sh_r[HS_PAD-2]};
    if (r2 >= SLOTS_V) begin
      r2 = r2 - SLOTS_V;
    end
    rem_nxt = r2[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        key_r  <= kc[KEY_W-1:0];
        sh_r   <= HS_PAD'(s);
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        sh_r  <= sh_r << 2;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NPAIR - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign key  = key_r;
  assign home = rem_r;
  assign done = done_r;

endmodule

`default_nettype wire

### rtl/core/oakt_step.sv
`default_nettype none

module oakt_step
  import oakt_pkg::*;
#(
  parameter int SLOTS = 32,
  localparam int POS_W = $clog2(SLOTS)
) (
  input  wire logic             clk,
  input  wire oakt_step_ctl_t   ctl,
  input  wire logic [POS_W-1:0] home,
  output logic      [POS_W-1:0] pos,
  output logic                  last
);

  localparam int BOUND = 6 * SLOTS;
  localparam int CNT_W = $clog2(BOUND);
  localparam logic [POS_W:0] SLOTS_V = (POS_W + 1)'(SLOTS);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] home_r;
  logic [POS_W-1:0] tri_r;
  logic [POS_W-1:0] ninc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] tri_nxt;

  function automatic logic [POS_W-1:0] mod_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SLOTS_V) begin
      sum = sum - SLOTS_V;
    end
    return sum[POS_W-1:0];
  endfunction

  assign pos_nxt = mod_add(pos_r, ctl.mode ? tri_r : POS_W'(1));
  assign tri_nxt = mod_add(tri_r, ninc_r);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_r  <= home;
      home_r <= home;
      tri_r  <= POS_W'(1);
      ninc_r <= POS_W'(2);
      cnt_r  <= '0;
    end else if (ctl.adv) begin
      pos_r  <= pos_nxt;
      tri_r  <= tri_nxt;
      ninc_r <= (ninc_r == POS_W'(SLOTS - 1)) ? '0 : ninc_r + 1'b1;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign pos  = pos_r;
  assign last = (pos_nxt == home_r) || (cnt_r == CNT_W'(BOUND - 1));

endmodule

`default_nettype wire

### rtl/core/open_addressing_key_table_unit.sv
`default_nettype none

// Open-addressing key table. A request beat on in_* carries a key of up to KEY_BYTES
// characters and asks to insert (tuser 0), remove (1) or look up (2) that key; each request
// returns one ok beat on out_*. The home slot is taken by an iterative remainder unit that
// resolves two hash bits per cycle and hands the slot to the probe walk when it is done.
// The walk then reads one slot of the key memory per cycle; the last read returns through
// the registered read port and the result is then posted from S_RESP. The walk visits up
// to SLOTS slots in linear mode and up to 6*SLOTS in triangular mode, and in_tready rises
// again in the same cycle as the result beat appears on out_*. An unknown request type
// skips the hash and the walk and goes straight to S_RESP with ok 0. A result that waits
// for out_tready holds the block until the previous result is taken. After reset the block
// runs a clearing pass over all SLOTS slots of the memory before in_tready rises; cfg_*
// writes are taken at any time.
module open_addressing_key_table_unit
  import oakt_pkg::*;
#(
  parameter int SLOTS = 32,
  parameter int KEY_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: key_bytes [62:0], key_length [66:63], zero fill.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: req_type [1:0].
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0: ok [0], zero fill.
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data
);

  localparam int POS_W = $clog2(SLOTS);
  localparam int KEY_W = (KEY_BYTES == 8) ? KEY_IN_W : 8 * KEY_BYTES;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_t;

  state_t         state_r;
  state_t         state_nxt;
  req_t           req_r;
  logic           mode_r;
  logic           ok_r;
  logic           out_tvalid_r;
  logic           out_ok_r;
  logic           issue_live_r;
  logic           rd_vld_r;
  logic           rd_last_r;
  logic [POS_W-1:0] rd_pos_r;
  logic [POS_W-1:0] clr_r;

  logic [KEY_W:0] mem [SLOTS];
  logic [KEY_W:0] rd_q;

  logic             in_acc;
  logic             out_free;
  logic             hash_done;
  logic [KEY_W-1:0] hash_key;
  logic [POS_W-1:0] hash_home;
  logic [POS_W-1:0] step_pos;
  logic             step_last;
  oakt_step_ctl_t   step_ctl;
  logic             ent_v;
  logic             hit;
  logic             probe_end;
  logic             mem_we;
  logic [POS_W-1:0] mem_wa;
  logic [KEY_W:0]   mem_wd;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  oakt_hash #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .key_bytes  (in_tdata[KEY_IN_W-1:0]),
    .key_length (in_tdata[KEY_IN_W+KEY_LEN_W-1:KEY_IN_W]),
    .key        (hash_key),
    .home       (hash_home),
    .done       (hash_done)
  );

  assign step_ctl.load = (state_r == S_HASH) && hash_done;
  assign step_ctl.adv  = (state_r == S_PROBE) && issue_live_r;
  assign step_ctl.mode = mode_r;

  oakt_step #(
    .SLOTS (SLOTS)
  ) u_step (
    .clk  (clk),
    .ctl  (step_ctl),
    .home (hash_home),
    .pos  (step_pos),
    .last (step_last)
  );

  assign ent_v = rd_q[KEY_W];
  assign hit = (req_r == REQ_INSERT) ? !ent_v : (ent_v && (rd_q[KEY_W-1:0] == hash_key));
  assign probe_end = (state_r == S_PROBE) && rd_vld_r && (hit || rd_last_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_pos_r;
    mem_wd = {(req_r == REQ_INSERT), hash_key};
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if ((state_r == S_PROBE) && rd_vld_r && hit && (req_r != REQ_LOOKUP)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[step_pos];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == POS_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == REQ_UNKNOWN) ? S_RESP : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      mode_r       <= 1'b0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      issue_live_r <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (in_acc) begin
        req_r <= req_t'(in_tuser);
        ok_r  <= 1'b0;
      end
      if (step_ctl.load) begin
        issue_live_r <= 1'b1;
        rd_vld_r     <= 1'b0;
      end else if (state_r == S_PROBE) begin
        rd_vld_r  <= issue_live_r;
        rd_pos_r  <= step_pos;
        rd_last_r <= step_last;
        if (issue_live_r) begin
          issue_live_r <= !step_last;
        end
        if (rd_vld_r && hit) begin
          ok_r <= 1'b1;
        end
      end
      if ((state_r == S_RESP) && out_free) begin
        out_tvalid_r <= 1'b1;
        out_ok_r     <= ok_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, out_ok_r};

endmodule

`default_nettype wire

### verif/oakt_table_monitor.sv
package oakt_tb_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_kind_t;

  localparam logic MODE_LINEAR     = 1'b0;
  localparam logic MODE_TRIANGULAR = 1'b1;

endpackage

module oakt_table_monitor
  import oakt_pkg::*;
  import oakt_tb_pkg::*;
#(
  parameter int SLOTS = 32,
  parameter int KEY_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_data,
  output int                     error_count,
  output int                     awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        slot_used [SLOTS];
  logic [63:0] slot_key [SLOTS];
  logic [3:0]  slot_len [SLOTS];
  logic        probe_tri;
  logic        pending_ok [$];
  logic        expected_ok;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Walks the probe path of one request and updates the shadow table.
  function automatic logic probe_table(input logic [1:0] kind,
                                       input logic [KEY_IN_W-1:0] raw,
                                       input logic [KEY_LEN_W-1:0] raw_len);
    logic [63:0] wide;
    logic [63:0] key;
    logic [7:0]  c;
    logic [31:0] h;
    int          lim;
    int          klen;
    int          home;
    int          pos;
    int          steps;
    logic        hit;
    logic        stop;
    wide = 64'(raw);
    key = '0;
    klen = 0;
    stop = 1'b0;
    lim = (raw_len > KEY_BYTES) ? KEY_BYTES : int'(raw_len);
    // The key ends at the first zero character.
    for (int i = 0; i < lim; i++) begin
      c = wide[8*i +: 8];
      if (c == 8'd0) stop = 1'b1;
      if (!stop) begin
        key[8*i +: 8] = c;
        klen++;
      end
    end
    h = '0;
    for (int i = 0; i < klen; i++) begin
      h = (h ^ 32'(key[8*i +: 8])) << 1;
    end
    home = int'(h % SLOTS);
    if (kind == REQ_UNKNOWN) return 1'b0;
    pos = home;
    steps = 0;
    hit = 1'b0;
    do begin
      if (kind == REQ_INSERT) begin
        if (!slot_used[pos]) begin
          slot_used[pos] = 1'b1;
          slot_key[pos] = key;
          slot_len[pos] = 4'(klen);
          hit = 1'b1;
        end
      end else if (slot_used[pos] && slot_key[pos] == key && slot_len[pos] == 4'(klen)) begin
        if (kind == REQ_REMOVE) slot_used[pos] = 1'b0;
        hit = 1'b1;
      end
      if (!hit) begin
        steps++;
        if (probe_tri == MODE_LINEAR) begin
          pos = (pos + 1) % SLOTS;
        end else begin
          pos = (pos + ((steps + steps * steps) / 2) % SLOTS) % SLOTS;
        end
      end
    end while (!hit && pos != home && steps < 6 * SLOTS);
    return hit;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
      end
      probe_tri = MODE_LINEAR;
      pending_ok.delete();
      error_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_ok.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          expected_ok = pending_ok.pop_front();
          if (out_tdata[0] !== expected_ok) begin
            report_mismatch($sformatf("ok is %b, expected %b", out_tdata[0], expected_ok));
          end
        end
      end
      if (cfg_valid && cfg_ready) probe_tri = cfg_data;
      if (in_tvalid && in_tready) begin
        pending_ok.push_back(probe_table(in_tuser, in_tdata[KEY_IN_W-1:0],
                                         in_tdata[KEY_IN_W +: KEY_LEN_W]));
      end
    end
    awaited = pending_ok.size();
  end

endmodule

### verif/tb_open_addressing_key_table_unit.sv
module tb_open_addressing_key_table_unit
  import oakt_pkg::*, oakt_tb_pkg::*;
  ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 32;
  localparam int KEY_BYTES = 8;
  localparam int POOL_SIZE = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 130;
  localparam int STALL_LIMIT = 4000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;

  int          send_idle_pct;
  int          sink_stall_pct;
  int          error_count;
  int          awaited;
  int          quiet_cycles;
  logic [63:0] pool_key [POOL_SIZE];
  int          pool_len [POOL_SIZE];

  open_addressing_key_table_unit #(
    .SLOTS(SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  oakt_table_monitor #(
    .SLOTS(SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) u_monitor (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .error_count(error_count),
    .awaited(awaited)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(input req_kind_t kind, input logic [KEY_IN_W-1:0] bytes,
                              input logic [KEY_LEN_W-1:0] len);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {{(IN_TDATA_W - KEY_IN_W - KEY_LEN_W){1'b0}}, len, bytes};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small pool so that removes and lookups hit, with random
  // characters beyond the key's end; the rest are random noise keys.
  task automatic pick_key(output logic [KEY_IN_W-1:0] bytes, output logic [KEY_LEN_W-1:0] len);
    logic [63:0] k;
    logic [63:0] junk;
    int          idx;
    int          keep;
    junk = {$urandom, $urandom};
    if ($urandom_range(99, 0) < 15) begin
      bytes = junk[KEY_IN_W-1:0];
      len = KEY_LEN_W'($urandom_range(15, 0));
    end else begin
      idx = $urandom_range(POOL_SIZE - 1, 0);
      k = pool_key[idx];
      keep = pool_len[idx];
      for (int i = keep; i < 8; i++) begin
        k[8*i +: 8] = junk[8*i +: 8];
      end
      if (keep < 8 && $urandom_range(1, 0) == 1) begin
        k[8*keep +: 8] = 8'd0;
        len = KEY_LEN_W'($urandom_range(15, keep + 1));
      end else if (keep == 8) begin
        len = KEY_LEN_W'($urandom_range(15, 8));
      end else begin
        len = KEY_LEN_W'(keep);
      end
      bytes = k[KEY_IN_W-1:0];
    end
  endtask

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int                  ins_pct;
    int                  rem_pct;
    int                  roll;
    int                  phase_idle;
    int                  phase_stall;
    logic [KEY_IN_W-1:0] bytes;
    logic [KEY_LEN_W-1:0] len;
    req_kind_t           kind;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = $urandom_range(8, 0);
      pool_key[p] = '0;
      for (int i = 0; i < pool_len[p]; i++) begin
        pool_key[p][8*i +: 8] = 8'((i == 7) ? $urandom_range(127, 1) : $urandom_range(255, 1));
      end
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    write_mode(MODE_LINEAR);

    send_request(REQ_LOOKUP, 63'h41, 4'd1);
    send_request(REQ_REMOVE, 63'h41, 4'd1);
    send_request(REQ_INSERT, 63'h0, 4'd0);
    send_request(REQ_LOOKUP, 63'h4142_4344_4546_4700, 4'd8);
    send_request(REQ_INSERT, 63'h7F7F_7F7F_7F7F_7F7F, 4'd8);
    send_request(REQ_INSERT, 63'h7F7F_7F7F_7F7F_7F7F, 4'd15);
    send_request(REQ_LOOKUP, 63'h7F7F_7F7F_7F7F_7F7F, 4'd9);
    send_request(REQ_REMOVE, 63'h7F7F_7F7F_7F7F_7F7F, 4'd8);
    send_request(REQ_REMOVE, 63'h7F7F_7F7F_7F7F_7F7F, 4'd8);
    send_request(REQ_REMOVE, 63'h7F7F_7F7F_7F7F_7F7F, 4'd8);
    send_request(REQ_LOOKUP, 63'h7F7F_7F7F_7F7F_7F7F, 4'd8);
    send_request(REQ_INSERT, {KEY_IN_W{1'b1}}, 4'd15);
    send_request(REQ_LOOKUP, {KEY_IN_W{1'b1}}, 4'd8);
    send_request(REQ_INSERT, 63'h44_4300_4241, 4'd5);
    send_request(REQ_LOOKUP, 63'h4241, 4'd2);
    send_request(REQ_LOOKUP, 63'h58_4241, 4'd3);
    send_request(REQ_UNKNOWN, 63'h4241, 4'd2);
    send_request(REQ_LOOKUP, 63'h4241, 4'd2);
    send_request(REQ_REMOVE, 63'h1234, 4'd0);
    send_request(REQ_LOOKUP, 63'h0, 4'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while (awaited != 0) @(negedge clk);
      write_mode((phase % 3 != 0) ? MODE_TRIANGULAR : MODE_LINEAR);
      case (phase % 4)
        0: begin
          phase_idle = 0;
          phase_stall = 0;
        end
        1: begin
          phase_idle = 62;
          phase_stall = 0;
        end
        2: begin
          phase_idle = 0;
          phase_stall = 62;
        end
        default: begin
          phase_idle = 27;
          phase_stall = 27;
        end
      endcase
      case ((phase / 2) % 4)
        0: begin
          ins_pct = 55;
          rem_pct = 15;
        end
        1: begin
          ins_pct = 30;
          rem_pct = 40;
        end
        2: begin
          ins_pct = 45;
          rem_pct = 25;
        end
        default: begin
          ins_pct = 25;
          rem_pct = 45;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Quiet stretches inside idling phases.
        if ((n % 40 >= 20) && (n % 40 < 30)) begin
          send_idle_pct = 0;
          sink_stall_pct = 0;
        end else begin
          send_idle_pct = phase_idle;
          sink_stall_pct = phase_stall;
        end
        roll = $urandom_range(99, 0);
        if (roll < ins_pct) kind = REQ_INSERT;
        else if (roll < ins_pct + rem_pct) kind = REQ_REMOVE;
        else if (roll < 96) kind = REQ_LOOKUP;
        else kind = REQ_UNKNOWN;
        pick_key(bytes, len);
        send_request(kind, bytes, len);
      end
    end

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
